### rtl/teq_pkg.sv
package teq_pkg;

    // Queue geometry and field widths
    localparam int DEPTH      = 16;
    localparam int EVENT_BITS = 8;
    localparam int TIME_BITS  = 32;
    localparam int CODE_BITS  = 8;
    localparam int DELAY_BITS = 16;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int IDX_BITS   = $clog2(DEPTH);

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [EVENT_BITS-1:0] t_event;
    typedef logic [DELAY_BITS-1:0] t_delay;
    typedef logic [CNT_BITS-1:0]   t_count;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                 cmd;
        logic [CODE_BITS-1:0] event_code;
        t_delay               delay_ms;
    } t_in_item;

    typedef struct packed {
        logic                 event_valid;
        logic [CODE_BITS-1:0] event_out;
        logic [4:0]           pending_count;
        logic                 dropped;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic remove;
        logic load_out;
    } t_dp_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic in_dequeue;
        logic scan_end;
        logic hit;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/teq_if.sv
interface teq_in_if;
    logic               valid;
    logic               ready;
    teq_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface teq_out_if;
    logic               valid;
    logic               ready;
    teq_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/teq_ctrl.sv
module teq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  teq_pkg::t_dp_stat i_stat,
    output teq_pkg::t_dp_ctrl o_ctrl
);

    teq_pkg::t_state r_state;
    teq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= teq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one transaction: accept, scan if dequeue, then post result
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        unique case (r_state)
            teq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.start = 1'b1;
                    n_state = i_stat.in_dequeue ? teq_pkg::S_SCAN : teq_pkg::S_RESULT;
                end
            end
            teq_pkg::S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = teq_pkg::S_RESULT;
                end else if (i_stat.hit) begin
                    o_ctrl.remove = 1'b1;
                    n_state = teq_pkg::S_RESULT;
                end else begin
                    o_ctrl.step = 1'b1;
                end
            end
            teq_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state = teq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = teq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/teq_dp.sv
module teq_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  teq_pkg::t_in_item  i_item,
    input  teq_pkg::t_dp_ctrl  i_ctrl,
    output teq_pkg::t_dp_stat  o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output teq_pkg::t_out_item o_out_item
);

    // Slot storage, slot 0 oldest
    teq_pkg::t_event r_slot_event [teq_pkg::DEPTH];
    teq_pkg::t_delay r_slot_delay [teq_pkg::DEPTH];
    teq_pkg::t_time  r_slot_stamp [teq_pkg::DEPTH];

    teq_pkg::t_time  r_now;
    teq_pkg::t_count r_count;
    teq_pkg::t_count r_idx;
    logic            r_out_valid;

    teq_pkg::t_event    r_evt;
    logic               r_found;
    logic               r_drop;
    teq_pkg::t_out_item r_out_item;

    logic                         w_full;
    logic [teq_pkg::IDX_BITS-1:0] w_rd_idx;
    logic [teq_pkg::IDX_BITS-1:0] w_wr_idx;
    teq_pkg::t_time               w_elapsed;
    logic                         w_hit;
    logic                         w_enq_ok;

    assign w_full    = r_count >= teq_pkg::t_count'(teq_pkg::DEPTH);
    assign w_rd_idx  = r_idx[teq_pkg::IDX_BITS-1:0];
    assign w_wr_idx  = r_count[teq_pkg::IDX_BITS-1:0];
    assign w_enq_ok  = (i_item.cmd == teq_pkg::CMD_ENQUEUE) && !w_full;

    // Expiry test on the slot under the scan pointer
    assign w_elapsed = r_now - r_slot_stamp[w_rd_idx];
    assign w_hit     = w_elapsed >= teq_pkg::t_time'(r_slot_delay[w_rd_idx]);

    assign o_stat.in_dequeue = i_item.cmd == teq_pkg::CMD_DEQUEUE;
    assign o_stat.scan_end   = r_idx >= r_count;
    assign o_stat.hit        = w_hit;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Clock, occupancy, scan pointer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.start) begin
                r_idx <= '0;
                case (i_item.cmd)
                    teq_pkg::CMD_TICK:    r_now <= r_now + teq_pkg::t_time'(1);
                    teq_pkg::CMD_ENQUEUE: begin
                        if (!w_full) begin
                            r_count <= r_count + teq_pkg::t_count'(1);
                        end
                    end
                    teq_pkg::CMD_CLEAR:   r_count <= '0;
                    default: ;
                endcase
            end
            if (i_ctrl.step) begin
                r_idx <= r_idx + teq_pkg::t_count'(1);
            end
            if (i_ctrl.remove) begin
                r_count <= r_count - teq_pkg::t_count'(1);
            end
            if (i_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Slot writes, close-up on removal, result capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_evt   <= '0;
            r_found <= 1'b0;
            r_drop  <= (i_item.cmd == teq_pkg::CMD_ENQUEUE) && w_full;
            if (w_enq_ok) begin
                r_slot_event[w_wr_idx] <= i_item.event_code[teq_pkg::EVENT_BITS-1:0];
                r_slot_delay[w_wr_idx] <= i_item.delay_ms;
                r_slot_stamp[w_wr_idx] <= r_now;
            end
        end
        if (i_ctrl.remove) begin
            r_found <= 1'b1;
            r_evt   <= r_slot_event[w_rd_idx];
            for (int j = 0; j < teq_pkg::DEPTH - 1; j++) begin
                if (teq_pkg::t_count'(j) >= r_idx) begin
                    r_slot_event[j] <= r_slot_event[j+1];
                    r_slot_delay[j] <= r_slot_delay[j+1];
                    r_slot_stamp[j] <= r_slot_stamp[j+1];
                end
            end
        end
        if (i_ctrl.load_out) begin
            r_out_item.event_valid   <= r_found;
            r_out_item.event_out     <= teq_pkg::CODE_BITS'(r_evt);
            r_out_item.pending_count <= 5'(r_count);
            r_out_item.dropped       <= r_drop;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= teq_pkg::t_count'(teq_pkg::DEPTH))
        else $error("occupancy above depth");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.remove |=> r_count == $past(r_count) - teq_pkg::t_count'(1))
        else $error("removal did not shrink the queue");

    a_remove_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.remove |-> (!o_stat.scan_end && w_hit))
        else $error("removal of a slot that is not due or not valid");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.dropped) |->
            r_out_item.pending_count == 5'(teq_pkg::DEPTH))
        else $error("drop flagged on a queue that was not full");

endmodule

### rtl/timed_event_queue.sv
// A tick, enqueue or clear is accepted in the idle state and its result is loaded into
// the output register from the result state once the output is free. A dequeue first
// scans up to 16 valid slots from slot 0 until it finds a due entry or none is left.
// A new transaction is accepted only after the last result is loaded; the scan tests
// one slot per cycle through a single subtract and compare.
// Reset (synchronous, active low) empties the queue, zeroes the millisecond clock and
// drops any result not yet taken; slot contents are not cleared.
module timed_event_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    teq_in_if.sink    i_in,
    teq_out_if.source o_out
);

    teq_pkg::t_dp_ctrl w_ctrl;
    teq_pkg::t_dp_stat w_stat;
    logic              w_in_ready;
    logic              w_out_valid;
    teq_pkg::t_out_item w_out_item;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_item;

    teq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    teq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.data),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

endmodule
